// ----- rtl/gnpr_pkg.sv -----
// ----------------------------------------------------------------------------
// gnpr_pkg
// Shared constants, request codes and types of the nearest-point height raster.
// ----------------------------------------------------------------------------
package gnpr_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int CELL_AW  = COL_W + ROW_W;
  localparam int NCELLS   = MAX_COLS * MAX_ROWS;
  localparam int QBITS    = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;
  localparam int POS_W    = QBITS - 1;
  localparam int GRID_W   = 7;
  localparam int OFF_W    = 31;
  localparam int SQ_W     = 2 * OFF_W - 2;
  localparam int DIST_W   = SQ_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_NOP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd5;

  typedef struct packed {
    logic [1:0]        req_type;
    logic signed [31:0] point_x;
    logic signed [31:0] point_height;
    logic signed [31:0] point_z;
    logic [5:0]        query_col;
    logic [5:0]        query_row;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] cell_height;
    logic              height_found;
    logic              filled_by_search;
  } out_res_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] best_dist;
    logic [31:0]       height;
  } cell_t;

  typedef struct packed {
    logic                    ok;
    logic [QBITS-1:0]        idx;
    logic signed [OFF_W-1:0] off;
  } bin_res_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_BIN, ST_MUL, ST_ADD, ST_UPD,
    ST_Q_RD, ST_Q_CHK, ST_SCAN_RD, ST_SCAN_CHK,
    ST_BFS_INIT, ST_POP, ST_POP_WAIT, ST_CUR_CHK, ST_NB_SEL, ST_NB_CHK,
    ST_CLN_RD, ST_CLN_WR, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIR_RIGHT, DIR_LEFT, DIR_UP, DIR_DOWN
  } scan_dir_t;

endpackage

// ----- rtl/grid_nearest_point_raster_unit.sv -----
// ----------------------------------------------------------------------------
// grid_nearest_point_raster_unit
// Nearest-point height raster over a grid of cells with query and search.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready as in_data and query results leave on
// out_valid/out_ready as out_data; clear and insert requests give no result.
// The cfg port writes one register per cycle; the user must use it only while
// idle, and the unit itself does not enforce this. One request is worked on
// at a time. In an insert the binning divider produces one quotient bit per
// cycle, then come a square, a sum and a read-modify-write of the cell
// memory. A clear sweeps the cell memory one entry per cycle. A query whose
// cell is set is answered from that one cell read; else the row and column
// scan reads further cells one at a time, and the fallback breadth-first
// search visits cells and their neighbors, then clears the visited mark of
// each visited cell. After reset the same sweep clears the cell and visited
// memories while in_ready stays low. A finished result waits in the output
// register; the next request is accepted meanwhile, and a later query holds
// in its final state until out_ready frees the register.
module grid_nearest_point_raster_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  gnpr_pkg::in_req_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output gnpr_pkg::out_res_t       out_data,
  input  logic                     cfg_we,
  input  logic [gnpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]              cfg_wdata
);

  localparam int AW  = gnpr_pkg::CELL_AW;
  localparam int TW  = AW + 1;
  localparam int GW  = gnpr_pkg::GRID_W;
  localparam int PW  = gnpr_pkg::POS_W;

  logic signed [31:0] origin_x_r, origin_z_r;
  logic [30:0]        step_x_r, step_z_r;
  logic [GW-1:0]      grid_cols_r, grid_rows_r;
  logic [GW-1:0]      cols_eff, rows_eff;

  gnpr_pkg::state_t   state_r, state_nxt;
  gnpr_pkg::in_req_t  req_r;
  gnpr_pkg::out_res_t res_r, out_data_r;
  gnpr_pkg::scan_dir_t dir_r, dir_nxt;
  logic               out_valid_r;
  logic [AW-1:0]      init_cnt_r;
  logic [gnpr_pkg::SQ_W-1:0]   sqx_r, sqz_r;
  logic [gnpr_pkg::DIST_W-1:0] dist_r;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [TW-1:0]      head_r, tail_r, cln_r;
  logic [AW-1:0]      cur_r;
  logic [1:0]         nbk_r;

  logic               bin_start, bx_done, bz_done;
  gnpr_pkg::bin_res_t bx_res, bz_res;
  logic signed [gnpr_pkg::OFF_W-1:0]   off_x, off_z;
  logic signed [2*gnpr_pkg::OFF_W-1:0] prod_x, prod_z;

  logic               cell_we;
  logic [AW-1:0]      cell_waddr, cell_raddr;
  gnpr_pkg::cell_t    cell_wdata, cell_rd;
  logic               vis_we, vis_wdata, vis_rd;
  logic [AW-1:0]      vis_waddr, vis_raddr;
  logic               que_we;
  logic [AW-1:0]      que_waddr, que_wdata, que_raddr, que_rd;

  logic [AW-1:0]      ins_addr, start_addr, scan_addr, nb_addr;
  logic               q_oor, nb_ok, sc_go, sc_cont, load_out;
  logic [2:0]         sc_from;
  logic [PW-1:0]      q_col, q_row, cc, cr;

  assign cols_eff = (grid_cols_r > GW'(gnpr_pkg::MAX_COLS)) ?
                    GW'(gnpr_pkg::MAX_COLS) : grid_cols_r;
  assign rows_eff = (grid_rows_r > GW'(gnpr_pkg::MAX_ROWS)) ?
                    GW'(gnpr_pkg::MAX_ROWS) : grid_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= '0;
      origin_z_r  <= '0;
      step_x_r    <= 31'd65536;
      step_z_r    <= 31'd65536;
      grid_cols_r <= GW'(64);
      grid_rows_r <= GW'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        gnpr_pkg::CFG_ORIGIN_X:  origin_x_r  <= cfg_wdata;
        gnpr_pkg::CFG_ORIGIN_Z:  origin_z_r  <= cfg_wdata;
        gnpr_pkg::CFG_STEP_X:    step_x_r    <= cfg_wdata[30:0];
        gnpr_pkg::CFG_STEP_Z:    step_z_r    <= cfg_wdata[30:0];
        gnpr_pkg::CFG_GRID_COLS: grid_cols_r <= cfg_wdata[GW-1:0];
        gnpr_pkg::CFG_GRID_ROWS: grid_rows_r <= cfg_wdata[GW-1:0];
        default: ;
      endcase
    end
  end

  assign bin_start = (state_r == gnpr_pkg::ST_IDLE) && in_valid &&
                     (in_data.req_type == gnpr_pkg::REQ_INSERT);

  gnpr_bin u_bin_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (bin_start),
    .coord  (in_data.point_x),
    .origin (origin_x_r),
    .step   (step_x_r),
    .limit  (cols_eff),
    .done   (bx_done),
    .res    (bx_res)
  );

  gnpr_bin u_bin_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (bin_start),
    .coord  (in_data.point_z),
    .origin (origin_z_r),
    .step   (step_z_r),
    .limit  (rows_eff),
    .done   (bz_done),
    .res    (bz_res)
  );

  gnpr_ram #(.WIDTH($bits(gnpr_pkg::cell_t)), .DEPTH(gnpr_pkg::NCELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rd)
  );

  gnpr_ram #(.WIDTH(1), .DEPTH(gnpr_pkg::NCELLS)) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rd)
  );

  gnpr_ram #(.WIDTH(AW), .DEPTH(gnpr_pkg::NCELLS)) u_queue_ram (
    .clk   (clk),
    .we    (que_we),
    .waddr (que_waddr),
    .wdata (que_wdata),
    .raddr (que_raddr),
    .rdata (que_rd)
  );

  assign off_x  = bx_res.off;
  assign off_z  = bz_res.off;
  assign prod_x = off_x * off_x;
  assign prod_z = off_z * off_z;

  assign q_col      = req_r.query_col;
  assign q_row      = req_r.query_row;
  assign q_oor      = ({1'b0, q_col} >= cols_eff) || ({1'b0, q_row} >= rows_eff);
  assign ins_addr   = {bz_res.idx[PW-1:0], bx_res.idx[PW-1:0]};
  assign start_addr = {q_row, q_col};
  assign scan_addr  = ((dir_r == gnpr_pkg::DIR_RIGHT) || (dir_r == gnpr_pkg::DIR_LEFT)) ?
                      {q_row, pos_r} : {pos_r, q_col};

  always_comb begin
    sc_cont = 1'b0;
    sc_from = 3'd0;
    pos_nxt = pos_r;
    dir_nxt = dir_r;
    sc_go   = 1'b1;
    if (state_r == gnpr_pkg::ST_SCAN_CHK) begin
      case (dir_r)
        gnpr_pkg::DIR_RIGHT: begin
          sc_cont = ({1'b0, pos_r} + 1'b1) < cols_eff;
          pos_nxt = pos_r + 1'b1;
          sc_from = 3'd1;
        end
        gnpr_pkg::DIR_LEFT: begin
          sc_cont = pos_r != '0;
          pos_nxt = pos_r - 1'b1;
          sc_from = 3'd2;
        end
        gnpr_pkg::DIR_UP: begin
          sc_cont = pos_r != '0;
          pos_nxt = pos_r - 1'b1;
          sc_from = 3'd3;
        end
        default: begin
          sc_cont = ({1'b0, pos_r} + 1'b1) < rows_eff;
          pos_nxt = pos_r + 1'b1;
          sc_from = 3'd4;
        end
      endcase
    end
    if (!sc_cont) begin
      if (sc_from == 3'd0 && ({1'b0, q_col} + 1'b1) < cols_eff) begin
        dir_nxt = gnpr_pkg::DIR_RIGHT;
        pos_nxt = q_col + 1'b1;
      end else if (sc_from <= 3'd1 && q_col != '0) begin
        dir_nxt = gnpr_pkg::DIR_LEFT;
        pos_nxt = q_col - 1'b1;
      end else if (sc_from <= 3'd2 && q_row != '0) begin
        dir_nxt = gnpr_pkg::DIR_UP;
        pos_nxt = q_row - 1'b1;
      end else if (sc_from <= 3'd3 && ({1'b0, q_row} + 1'b1) < rows_eff) begin
        dir_nxt = gnpr_pkg::DIR_DOWN;
        pos_nxt = q_row + 1'b1;
      end else begin
        sc_go = 1'b0;
      end
    end
  end

  assign cc = cur_r[PW-1:0];
  assign cr = cur_r[AW-1:PW];

  always_comb begin
    case (nbk_r)
      2'd0: begin
        nb_ok   = cc != '0;
        nb_addr = cur_r - 1'b1;
      end
      2'd1: begin
        nb_ok   = ({1'b0, cc} + 1'b1) < cols_eff;
        nb_addr = cur_r + 1'b1;
      end
      2'd2: begin
        nb_ok   = cr != '0;
        nb_addr = cur_r - AW'(gnpr_pkg::MAX_COLS);
      end
      default: begin
        nb_ok   = ({1'b0, cr} + 1'b1) < rows_eff;
        nb_addr = cur_r + AW'(gnpr_pkg::MAX_COLS);
      end
    endcase
  end

  assign load_out = (state_r == gnpr_pkg::ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gnpr_pkg::ST_INIT:
        if (init_cnt_r == AW'(gnpr_pkg::NCELLS - 1)) state_nxt = gnpr_pkg::ST_IDLE;
      gnpr_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_data.req_type)
            gnpr_pkg::REQ_CLEAR:  state_nxt = gnpr_pkg::ST_INIT;
            gnpr_pkg::REQ_INSERT: state_nxt = gnpr_pkg::ST_BIN;
            gnpr_pkg::REQ_QUERY:  state_nxt = gnpr_pkg::ST_Q_RD;
            default:              state_nxt = gnpr_pkg::ST_IDLE;
          endcase
        end
      end
      gnpr_pkg::ST_BIN:
        if (bx_done) begin
          state_nxt = (bx_res.ok && bz_res.ok && bz_done) ?
                      gnpr_pkg::ST_MUL : gnpr_pkg::ST_IDLE;
        end
      gnpr_pkg::ST_MUL:     state_nxt = gnpr_pkg::ST_ADD;
      gnpr_pkg::ST_ADD:     state_nxt = gnpr_pkg::ST_UPD;
      gnpr_pkg::ST_UPD:     state_nxt = gnpr_pkg::ST_IDLE;
      gnpr_pkg::ST_Q_RD:
        state_nxt = q_oor ? gnpr_pkg::ST_DONE : gnpr_pkg::ST_Q_CHK;
      gnpr_pkg::ST_Q_CHK, gnpr_pkg::ST_SCAN_CHK: begin
        if (cell_rd.valid) begin
          state_nxt = gnpr_pkg::ST_DONE;
        end else begin
          state_nxt = sc_go ? gnpr_pkg::ST_SCAN_RD : gnpr_pkg::ST_BFS_INIT;
        end
      end
      gnpr_pkg::ST_SCAN_RD:  state_nxt = gnpr_pkg::ST_SCAN_CHK;
      gnpr_pkg::ST_BFS_INIT: state_nxt = gnpr_pkg::ST_POP;
      gnpr_pkg::ST_POP:
        state_nxt = (head_r == tail_r) ? gnpr_pkg::ST_CLN_RD : gnpr_pkg::ST_POP_WAIT;
      gnpr_pkg::ST_POP_WAIT: state_nxt = gnpr_pkg::ST_CUR_CHK;
      gnpr_pkg::ST_CUR_CHK:
        state_nxt = ((cur_r != start_addr) && cell_rd.valid) ?
                    gnpr_pkg::ST_CLN_RD : gnpr_pkg::ST_NB_SEL;
      gnpr_pkg::ST_NB_SEL: begin
        if (nb_ok) begin
          state_nxt = gnpr_pkg::ST_NB_CHK;
        end else if (nbk_r == 2'd3) begin
          state_nxt = gnpr_pkg::ST_POP;
        end
      end
      gnpr_pkg::ST_NB_CHK:
        state_nxt = (nbk_r == 2'd3) ? gnpr_pkg::ST_POP : gnpr_pkg::ST_NB_SEL;
      gnpr_pkg::ST_CLN_RD:
        state_nxt = (cln_r == tail_r) ? gnpr_pkg::ST_DONE : gnpr_pkg::ST_CLN_WR;
      gnpr_pkg::ST_CLN_WR:   state_nxt = gnpr_pkg::ST_CLN_RD;
      gnpr_pkg::ST_DONE:
        if (load_out) state_nxt = gnpr_pkg::ST_IDLE;
      default:               state_nxt = gnpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = state_r == gnpr_pkg::ST_IDLE;
    cell_we    = 1'b0;
    cell_waddr = init_cnt_r;
    cell_wdata = '0;
    cell_raddr = '0;
    vis_we     = 1'b0;
    vis_waddr  = init_cnt_r;
    vis_wdata  = 1'b0;
    vis_raddr  = nb_addr;
    que_we     = 1'b0;
    que_waddr  = tail_r[AW-1:0];
    que_wdata  = nb_addr;
    que_raddr  = head_r[AW-1:0];
    case (state_r)
      gnpr_pkg::ST_INIT: begin
        cell_we = 1'b1;
        vis_we  = 1'b1;
      end
      gnpr_pkg::ST_ADD:      cell_raddr = ins_addr;
      gnpr_pkg::ST_UPD: begin
        cell_we              = !cell_rd.valid || (dist_r < cell_rd.best_dist);
        cell_waddr           = ins_addr;
        cell_wdata.valid     = 1'b1;
        cell_wdata.best_dist = dist_r;
        cell_wdata.height    = req_r.point_height;
      end
      gnpr_pkg::ST_Q_RD:     cell_raddr = start_addr;
      gnpr_pkg::ST_SCAN_RD:  cell_raddr = scan_addr;
      gnpr_pkg::ST_BFS_INIT: begin
        vis_we    = 1'b1;
        vis_waddr = start_addr;
        vis_wdata = 1'b1;
        que_we    = 1'b1;
        que_waddr = '0;
        que_wdata = start_addr;
      end
      gnpr_pkg::ST_POP_WAIT: cell_raddr = que_rd;
      gnpr_pkg::ST_NB_CHK: begin
        vis_we    = !vis_rd;
        vis_waddr = nb_addr;
        vis_wdata = 1'b1;
        que_we    = !vis_rd;
      end
      gnpr_pkg::ST_CLN_RD:   que_raddr = cln_r[AW-1:0];
      gnpr_pkg::ST_CLN_WR: begin
        vis_we    = 1'b1;
        vis_waddr = que_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gnpr_pkg::ST_INIT;
      init_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      cln_r       <= '0;
      nbk_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        gnpr_pkg::ST_INIT: init_cnt_r <= init_cnt_r + 1'b1;
        gnpr_pkg::ST_IDLE: init_cnt_r <= '0;
        gnpr_pkg::ST_BFS_INIT: begin
          head_r <= '0;
          tail_r <= TW'(1);
          cln_r  <= '0;
        end
        gnpr_pkg::ST_POP: begin
          if (head_r != tail_r) begin
            head_r <= head_r + 1'b1;
          end else begin
            cln_r <= '0;
          end
        end
        gnpr_pkg::ST_CUR_CHK: begin
          nbk_r <= '0;
          cln_r <= '0;
        end
        gnpr_pkg::ST_NB_SEL:
          if (!nb_ok && nbk_r != 2'd3) nbk_r <= nbk_r + 1'b1;
        gnpr_pkg::ST_NB_CHK: begin
          if (!vis_rd) tail_r <= tail_r + 1'b1;
          if (nbk_r != 2'd3) nbk_r <= nbk_r + 1'b1;
        end
        gnpr_pkg::ST_CLN_RD:
          if (cln_r != tail_r) cln_r <= cln_r + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_data_r <= res_r;
    case (state_r)
      gnpr_pkg::ST_IDLE: req_r <= in_data;
      gnpr_pkg::ST_MUL: begin
        sqx_r <= prod_x[gnpr_pkg::SQ_W-1:0];
        sqz_r <= prod_z[gnpr_pkg::SQ_W-1:0];
      end
      gnpr_pkg::ST_ADD: dist_r <= {1'b0, sqx_r} + {1'b0, sqz_r};
      gnpr_pkg::ST_Q_RD: res_r <= '0;
      gnpr_pkg::ST_Q_CHK, gnpr_pkg::ST_SCAN_CHK: begin
        if (cell_rd.valid) begin
          res_r.cell_height      <= cell_rd.height;
          res_r.height_found     <= 1'b1;
          res_r.filled_by_search <= state_r == gnpr_pkg::ST_SCAN_CHK;
        end else begin
          dir_r <= dir_nxt;
          pos_r <= pos_nxt;
        end
      end
      gnpr_pkg::ST_BFS_INIT: res_r <= '0;
      gnpr_pkg::ST_POP_WAIT: cur_r <= que_rd;
      gnpr_pkg::ST_CUR_CHK: begin
        if ((cur_r != start_addr) && cell_rd.valid) begin
          res_r.cell_height      <= cell_rd.height;
          res_r.height_found     <= 1'b1;
          res_r.filled_by_search <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gnpr_pkg::ST_INIT) |-> !in_ready)
    else $error("request accepted during memory sweep");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= tail_r) && (cln_r <= tail_r) && (tail_r <= TW'(gnpr_pkg::NCELLS)))
    else $error("search queue pointers out of order");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gnpr_pkg::ST_DONE && !out_valid_r) |=> out_valid_r)
    else $error("finished query not presented");
`endif

endmodule

// ----- rtl/gnpr_ram.sv -----
// ----------------------------------------------------------------------------
// gnpr_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gnpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/gnpr_bin.sv -----
// ----------------------------------------------------------------------------
// gnpr_bin
// Bins one coordinate: floor((2d + s) / 2s) by restoring division, one
// quotient bit per cycle, plus the signed offset from the cell center.
// ----------------------------------------------------------------------------
module gnpr_bin (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [31:0]    coord,
  input  logic signed [31:0]    origin,
  input  logic [30:0]           step,
  input  logic [gnpr_pkg::GRID_W-1:0] limit,
  output logic                  done,
  output gnpr_pkg::bin_res_t    res
);

  localparam int XW  = 33 + gnpr_pkg::QBITS;
  localparam int CW  = $clog2(gnpr_pkg::QBITS);

  logic signed [32:0] d;
  logic [30:0]        s;
  logic signed [34:0] num;
  logic [XW-1:0]      div_full;
  logic [XW-1:0]      shifted;

  logic                     busy_r;
  logic                     done_r;
  logic [CW-1:0]            cnt_r;
  logic [XW-1:0]            rem_r;
  logic [31:0]              div_r;
  logic [30:0]              s_r;
  logic                     bad_r;
  logic [gnpr_pkg::QBITS-1:0] q_r;
  logic signed [32:0]       diff;

  assign d        = {coord[31], coord} - {origin[31], origin};
  assign s        = (step == '0) ? 31'd1 : step;
  assign num      = ({{2{d[32]}}, d} <<< 1) + $signed({4'b0, s});
  assign div_full = XW'({s, 1'b0}) << gnpr_pkg::QBITS;
  assign shifted  = XW'(div_r) << cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(gnpr_pkg::QBITS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[34] ? '0 : XW'(num[33:0]);
      bad_r <= num[34] || (XW'(num[33:0]) >= div_full);
      div_r <= {s, 1'b0};
      s_r   <= s;
      q_r   <= '0;
    end else if (busy_r) begin
      if (rem_r >= shifted) begin
        rem_r      <= rem_r - shifted;
        q_r[cnt_r] <= 1'b1;
      end
    end
  end

  assign diff     = $signed({1'b0, rem_r[31:0]}) - $signed({2'b0, s_r});
  assign done     = done_r;
  assign res.ok   = !bad_r && (q_r < limit);
  assign res.idx  = q_r;
  assign res.off  = diff[31:1];

endmodule
